### hw/rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// Point density classifier package
// Shared types, constants and codes for the point density classifier.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // Capacity and field widths.
  localparam int PDC_MAX_POINTS = 64;
  localparam int PDC_COORD_W    = 24;
  localparam int PDC_SQ_W       = 2 * PDC_COORD_W;
  localparam int PDC_RADIUS_W   = 51;
  localparam int PDC_LEVEL_W    = 7;
  localparam int PDC_INDEX_W    = 6;
  localparam int PDC_CFG_IDX_W  = 2;

  // Reset values of the configuration registers.
  localparam logic [PDC_RADIUS_W-1:0] PDC_RADIUS_RST   = 51'd4194304;
  localparam logic [PDC_LEVEL_W-1:0]  PDC_CRITICAL_RST = 7'd10;
  localparam logic [PDC_LEVEL_W-1:0]  PDC_MARGINAL_RST = 7'd5;

  // Configuration register indexes.
  localparam logic [PDC_CFG_IDX_W-1:0] CFG_RADIUS_SQUARED = 2'd0;
  localparam logic [PDC_CFG_IDX_W-1:0] CFG_CRITICAL_LEVEL = 2'd1;
  localparam logic [PDC_CFG_IDX_W-1:0] CFG_MARGINAL_LEVEL = 2'd2;

  // Severity codes.
  localparam logic [1:0] SEV_NONE     = 2'd0;
  localparam logic [1:0] SEV_MARGINAL = 2'd1;
  localparam logic [1:0] SEV_CRITICAL = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic signed [PDC_COORD_W-1:0] point_x;
    logic signed [PDC_COORD_W-1:0] point_y;
    logic                          last_point;
  } pdc_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [PDC_INDEX_W-1:0] point_index;
    logic [PDC_LEVEL_W-1:0] density;
    logic [1:0]             severity;
    logic                   last_result;
  } pdc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;    // store the incoming point
    logic issue;    // a pair (i, j) enters the distance pipeline
    logic first_j;  // first pair of a row
    logic last_j;   // last pair of a row
    logic last_i;   // row of the final stored point
  } pdc_cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EVAL,
    ST_DRAIN
  } pdc_state_t;

endpackage

### hw/rtl/pdc_ctrl.sv
// ----------------------------------------------------------------------------
// Point density classifier controller
// Counts loaded points and sequences the pair sweep over the stored set.
// ----------------------------------------------------------------------------
module pdc_ctrl import pdc_pkg::*; #(
  parameter int MAX_POINTS = PDC_MAX_POINTS,
  localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             last_point,
  input  logic             pipe_active,
  output logic             busy,
  output pdc_cmd_t         cmd,
  output logic [IDX_W-1:0] wr_addr,
  output logic [IDX_W-1:0] rd_i,
  output logic [IDX_W-1:0] rd_j
);

  pdc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             row_end;
  logic             set_end;

  // Sweep position compared against the last held point.
  assign row_end = (CNT_W'(j_r) == (count_r - CNT_W'(1)));
  assign set_end = (CNT_W'(i_r) == (count_r - CNT_W'(1)));

  assign busy    = (state_r != ST_LOAD);
  assign wr_addr = count_r[IDX_W-1:0];
  assign rd_i    = i_r;
  assign rd_j    = j_r;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cmd         = '0;
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          // A point beyond capacity is dropped but still may close the set.
          if (count_r < CNT_W'(MAX_POINTS)) begin
            cmd.wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (last_point) begin
            state_nxt = ST_EVAL;
            i_nxt     = '0;
            j_nxt     = '0;
          end
        end
      end
      ST_EVAL: begin
        cmd.issue   = 1'b1;
        cmd.first_j = (j_r == '0);
        cmd.last_j  = row_end;
        cmd.last_i  = set_end;
        if (row_end) begin
          j_nxt = '0;
          if (set_end) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // Wait for the last pair to leave the pipeline, then empty the store.
        if (!pipe_active) begin
          state_nxt = ST_LOAD;
          count_nxt = '0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

### hw/rtl/pdc_dp.sv
// ----------------------------------------------------------------------------
// Point density classifier datapath
// Point store, distance pipeline, neighbor counter and severity classifier.
// ----------------------------------------------------------------------------
module pdc_dp import pdc_pkg::*; #(
  parameter int MAX_POINTS = PDC_MAX_POINTS,
  localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [PDC_CFG_IDX_W-1:0] cfg_index,
  input  logic [PDC_RADIUS_W-1:0]  cfg_data,
  input  pdc_in_t                  in_data,
  input  pdc_cmd_t                 cmd,
  input  logic [IDX_W-1:0]         wr_addr,
  input  logic [IDX_W-1:0]         rd_i,
  input  logic [IDX_W-1:0]         rd_j,
  output logic                     pipe_active,
  output logic                     out_valid,
  output pdc_out_t                 out_data
);

  // Configuration registers.
  logic [PDC_RADIUS_W-1:0] radius_r;
  logic [PDC_LEVEL_W-1:0]  critical_r;
  logic [PDC_LEVEL_W-1:0]  marginal_r;

  // Point store.
  logic [PDC_COORD_W-1:0] x_mem [MAX_POINTS];
  logic [PDC_COORD_W-1:0] y_mem [MAX_POINTS];

  // Pipeline control bits, one set per stage.
  logic             v1_r, v2_r, v3_r, v4_r;
  logic             fj1_r, fj2_r, fj3_r, fj4_r;
  logic             lj1_r, lj2_r, lj3_r, lj4_r;
  logic             li1_r, li2_r, li3_r, li4_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r, idx4_r;

  // Pipeline payload.
  logic signed [PDC_COORD_W-1:0] xi_r, yi_r, xj_r, yj_r;
  logic signed [PDC_COORD_W:0]   dx, dy;
  logic [PDC_COORD_W-1:0]        adx_r, ady_r;
  logic [PDC_SQ_W-1:0]           sqx_r, sqy_r;
  logic [PDC_SQ_W:0]             pair_dist;
  logic                          hit_r;

  // Counter and result.
  logic [PDC_LEVEL_W-1:0] acc_r, acc_nxt;
  logic [1:0]             sev;
  logic                   out_valid_r;
  pdc_out_t               out_data_r;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= PDC_RADIUS_RST;
      critical_r <= PDC_CRITICAL_RST;
      marginal_r <= PDC_MARGINAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS_SQUARED: radius_r   <= cfg_data;
        CFG_CRITICAL_LEVEL: critical_r <= cfg_data[PDC_LEVEL_W-1:0];
        CFG_MARGINAL_LEVEL: marginal_r <= cfg_data[PDC_LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Store write port and the two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      x_mem[wr_addr] <= in_data.point_x;
      y_mem[wr_addr] <= in_data.point_y;
    end
    xi_r <= x_mem[rd_i];
    yi_r <= y_mem[rd_i];
    xj_r <= x_mem[rd_j];
    yj_r <= y_mem[rd_j];
  end

  // Signed coordinate differences; their magnitudes are registered below.
  assign dx = (PDC_COORD_W+1)'(xj_r) - (PDC_COORD_W+1)'(xi_r);
  assign dy = (PDC_COORD_W+1)'(yj_r) - (PDC_COORD_W+1)'(yi_r);

  // Squared distance of the pair.
  assign pair_dist = (PDC_SQ_W+1)'(sqx_r) + (PDC_SQ_W+1)'(sqy_r);

  // Pipeline control shift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Pipeline payload and tags.
  always_ff @(posedge clk) begin
    fj1_r  <= cmd.first_j;
    lj1_r  <= cmd.last_j;
    li1_r  <= cmd.last_i;
    idx1_r <= rd_i;
    fj2_r  <= fj1_r;
    lj2_r  <= lj1_r;
    li2_r  <= li1_r;
    idx2_r <= idx1_r;
    fj3_r  <= fj2_r;
    lj3_r  <= lj2_r;
    li3_r  <= li2_r;
    idx3_r <= idx2_r;
    fj4_r  <= fj3_r;
    lj4_r  <= lj3_r;
    li4_r  <= li3_r;
    idx4_r <= idx3_r;
    adx_r  <= dx[PDC_COORD_W] ? PDC_COORD_W'(-dx) : PDC_COORD_W'(dx);
    ady_r  <= dy[PDC_COORD_W] ? PDC_COORD_W'(-dy) : PDC_COORD_W'(dy);
    sqx_r  <= adx_r * adx_r;
    sqy_r  <= ady_r * ady_r;
    hit_r  <= (PDC_RADIUS_W'(pair_dist) <= radius_r);
  end

  // Neighbor count for the current row and its severity.
  always_comb begin
    acc_nxt = (fj4_r ? '0 : acc_r) + PDC_LEVEL_W'(hit_r);
    if (acc_nxt >= critical_r) begin
      sev = SEV_CRITICAL;
    end else if (acc_nxt >= marginal_r) begin
      sev = SEV_MARGINAL;
    end else begin
      sev = SEV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Result register: one transaction at the end of each row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v4_r && lj4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && lj4_r) begin
      out_data_r.point_index <= PDC_INDEX_W'(idx4_r);
      out_data_r.density     <= acc_nxt;
      out_data_r.severity    <= sev;
      out_data_r.last_result <= li4_r;
    end
  end

  assign pipe_active = v1_r | v2_r | v3_r | v4_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

endmodule

### hw/rtl/point_density_classifier_core.sv
// Each accepted point is written to the store; after the last point of a
// set of n points the pair sweep yields one result per stored point.
// The single distance pipeline takes one point pair per cycle (64 per point
// at 64 points); new points wait while busy until the set is done.
// Reset (synchronous, rst_n low) empties the store and restores register
// defaults; results are strobed for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
// Point density classifier core
// Fixed-radius neighbor count and severity classification of a point set.
// ----------------------------------------------------------------------------
module point_density_classifier_core import pdc_pkg::*; #(
  parameter int MAX_POINTS = PDC_MAX_POINTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [PDC_CFG_IDX_W-1:0] cfg_index,
  input  logic [PDC_RADIUS_W-1:0]  cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  pdc_in_t                  in_data,
  output logic                     out_valid,
  output pdc_out_t                 out_data
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  pdc_cmd_t         cmd;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_i;
  logic [IDX_W-1:0] rd_j;
  logic             pipe_active;

  // Controller: load counting and pair sweep.
  pdc_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .last_point  (in_data.last_point),
    .pipe_active (pipe_active),
    .busy        (busy),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .rd_i        (rd_i),
    .rd_j        (rd_j)
  );

  // Datapath: store, distance pipeline and classifier.
  pdc_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .rd_i        (rd_i),
    .rd_j        (rd_j),
    .pipe_active (pipe_active),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

### bench/point_density_classifier_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point density classifier core testbench
// Loads point sets into the core under several register settings and checks
// every strobed result against a neighbor count computed here in parallel.
// ----------------------------------------------------------------------------
module point_density_classifier_core_tb;
  import pdc_pkg::*;

  localparam int ITEM_TARGET    = 180;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [PDC_CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [PDC_RADIUS_W-1:0]  RADIUS_FULL  = '1;
  localparam logic [PDC_COORD_W-1:0]   COORD_MIN    = 24'h800000;
  localparam logic [PDC_COORD_W-1:0]   COORD_MAX    = 24'h7FFFFF;

  // Tracks the held point set and the register copies, and queues the
  // density results that each closed set should produce.
  class density_scoreboard;
    logic signed [PDC_COORD_W-1:0] x_held [PDC_MAX_POINTS];
    logic signed [PDC_COORD_W-1:0] y_held [PDC_MAX_POINTS];
    int unsigned                   points_held;
    logic [PDC_RADIUS_W-1:0]       radius_sq;
    logic [PDC_LEVEL_W-1:0]        critical_lvl;
    logic [PDC_LEVEL_W-1:0]        marginal_lvl;
    pdc_out_t                      awaited_densities [$];
    int unsigned                   errors;

    function new();
      points_held  = 0;
      radius_sq    = PDC_RADIUS_RST;
      critical_lvl = PDC_CRITICAL_RST;
      marginal_lvl = PDC_MARGINAL_RST;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return awaited_densities.size();
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    // Register writes to an unmapped index leave the copies untouched.
    function void set_register(logic [PDC_CFG_IDX_W-1:0] idx,
                               logic [PDC_RADIUS_W-1:0] value);
      case (idx)
        CFG_RADIUS_SQUARED: begin
          radius_sq = value;
        end
        CFG_CRITICAL_LEVEL: begin
          critical_lvl = value[PDC_LEVEL_W-1:0];
        end
        CFG_MARGINAL_LEVEL: begin
          marginal_lvl = value[PDC_LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Exact squared distance between two held points.
    function longint unsigned dist_sq(int unsigned a, int unsigned b);
      longint dx;
      longint dy;
      dx = x_held[a] - x_held[b];
      dy = y_held[a] - y_held[b];
      return longint'(dx * dx + dy * dy);
    endfunction

    // Stores an accepted point; a point marked last closes the set and
    // produces one expected result per held point in load order.
    function void note_point(pdc_in_t p);
      int unsigned i;
      int unsigned j;
      int unsigned hits;
      pdc_out_t    r;
      if (points_held < PDC_MAX_POINTS) begin
        x_held[points_held] = p.point_x;
        y_held[points_held] = p.point_y;
        points_held++;
      end
      if (!p.last_point) return;
      for (i = 0; i < points_held; i++) begin
        hits = 0;
        for (j = 0; j < points_held; j++) begin
          if (dist_sq(i, j) <= radius_sq) hits++;
        end
        r.point_index = PDC_INDEX_W'(i);
        r.density     = PDC_LEVEL_W'(hits);
        // The critical level is tested first, whatever the marginal level.
        if (r.density >= critical_lvl) begin
          r.severity = SEV_CRITICAL;
        end else if (r.density >= marginal_lvl) begin
          r.severity = SEV_MARGINAL;
        end else begin
          r.severity = SEV_NONE;
        end
        r.last_result = (i + 1 == points_held);
        awaited_densities.push_back(r);
      end
      points_held = 0;
    endfunction

    // Compares one strobed result with the oldest expectation.
    function void check_result(pdc_out_t got);
      pdc_out_t want;
      if (awaited_densities.size() == 0) begin
        flag_error($sformatf("unexpected result: index %0d density %0d sev %0d last %0b",
                             got.point_index, got.density, got.severity,
                             got.last_result));
        return;
      end
      want = awaited_densities.pop_front();
      if (got.point_index !== want.point_index || got.density !== want.density ||
          got.severity !== want.severity || got.last_result !== want.last_result) begin
        flag_error($sformatf({"mismatch: expected index %0d density %0d sev %0d last %0b,",
                              " got index %0d density %0d sev %0d last %0b"},
                             want.point_index, want.density, want.severity,
                             want.last_result, got.point_index, got.density,
                             got.severity, got.last_result));
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [PDC_CFG_IDX_W-1:0] cfg_index = CFG_RADIUS_SQUARED;
  logic [PDC_RADIUS_W-1:0]  cfg_data = '0;
  logic                     start = 1'b0;
  logic                     busy;
  pdc_in_t                  in_data = '0;
  logic                     out_valid;
  pdc_out_t                 out_data;

  density_scoreboard sb = new();
  int unsigned       items_sent = 0;
  int unsigned       burst_left = 0;
  int unsigned       quiet_cycles = 0;

  point_density_classifier_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_data);
    end
  end

  // The watchdog ends a run in which no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pdc_in_t make_point(logic [PDC_COORD_W-1:0] x,
                                         logic [PDC_COORD_W-1:0] y, logic last);
    pdc_in_t p;
    p.point_x    = x;
    p.point_y    = y;
    p.last_point = last;
    return p;
  endfunction

  // The sender works in bursts of random length separated by random gaps.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offers one point and waits for the core to take it.
  task automatic send_point(pdc_in_t p);
    pace_sender();
    start   <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy);
    sb.note_point(p);
    items_sent++;
  endtask

  // Waits until every result has arrived and the core has settled.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [PDC_CFG_IDX_W-1:0] idx, logic [PDC_RADIUS_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // Rewrites all three registers while the core is idle.
  task automatic write_config(logic [PDC_RADIUS_W-1:0] radius,
                              logic [PDC_RADIUS_W-1:0] critical,
                              logic [PDC_RADIUS_W-1:0] marginal);
    wait_idle();
    cfg_write(CFG_RADIUS_SQUARED, radius);
    cfg_write(CFG_CRITICAL_LEVEL, critical);
    cfg_write(CFG_MARGINAL_LEVEL, marginal);
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(CFG_UNMAPPED, PDC_RADIUS_W'({$urandom, $urandom}));
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PDC_RADIUS_W-1:0] pick_radius();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return PDC_RADIUS_RST;
      2: return RADIUS_FULL;
      3: return PDC_RADIUS_W'($urandom_range(0, 1 << 20));
      4: return PDC_RADIUS_W'($urandom);
      default: return PDC_RADIUS_W'({$urandom, $urandom});
    endcase
  endfunction

  // Levels mostly sit where small densities cross them; some carry junk in
  // the upper data bits, which the core must mask off.
  function automatic logic [PDC_RADIUS_W-1:0] pick_level();
    case ($urandom_range(0, 4))
      0, 1: return PDC_RADIUS_W'($urandom_range(0, 12));
      2: return PDC_RADIUS_W'($urandom_range(0, 65));
      3: return PDC_RADIUS_W'({$urandom, $urandom});
      default: return PDC_RADIUS_W'(($urandom_range(0, 1) == 0) ? 0 : 65);
    endcase
  endfunction

  // Loads a clustered set of n points; a few coordinates land on the extremes.
  task automatic random_set(int unsigned n);
    logic [PDC_COORD_W-1:0] cx;
    logic [PDC_COORD_W-1:0] cy;
    logic [PDC_COORD_W-1:0] px;
    logic [PDC_COORD_W-1:0] py;
    int                     spread;
    int unsigned            k;
    cx = PDC_COORD_W'($urandom);
    cy = PDC_COORD_W'($urandom);
    case ($urandom_range(0, 4))
      0: spread = 0;
      1: spread = 64;
      2: spread = 2048;
      3: spread = 65536;
      default: spread = 8388607;
    endcase
    for (k = 0; k < n; k++) begin
      px = cx + PDC_COORD_W'($urandom_range(0, 2 * spread) - spread);
      py = cy + PDC_COORD_W'($urandom_range(0, 2 * spread) - spread);
      if ($urandom_range(0, 15) == 0) begin
        px = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
      end
      if ($urandom_range(0, 15) == 0) begin
        py = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
      end
      send_point(make_point(px, py, k + 1 == n));
    end
  endtask

  initial begin
    int unsigned set_size;
    bit          first_set;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: a lone point, then extremes, duplicates and points
    // exactly on and just past the default radius.
    send_point(make_point(24'd0, 24'd0, 1'b1));
    send_point(make_point(COORD_MIN, COORD_MIN, 1'b0));
    send_point(make_point(COORD_MAX, COORD_MAX, 1'b0));
    send_point(make_point(COORD_MIN, COORD_MAX, 1'b0));
    send_point(make_point(COORD_MAX, COORD_MIN, 1'b0));
    send_point(make_point(24'd0, 24'd0, 1'b0));
    send_point(make_point(24'd0, 24'd0, 1'b0));
    send_point(make_point(24'd2048, 24'd0, 1'b0));
    send_point(make_point(24'd2049, 24'd0, 1'b0));
    send_point(make_point(24'd0, -24'sd2048, 1'b1));

    // Widest radius, with the marginal level above the critical one.
    write_config(RADIUS_FULL, 51'd3, 51'd7);
    send_point(make_point(COORD_MIN, COORD_MIN, 1'b0));
    send_point(make_point(COORD_MAX, COORD_MAX, 1'b0));
    send_point(make_point(COORD_MIN, COORD_MAX, 1'b0));
    send_point(make_point(24'd5, -24'sd5, 1'b0));
    send_point(make_point(COORD_MAX, COORD_MIN, 1'b1));

    // Zero radius counts only coincident points; a zero critical level
    // makes every point critical. The marginal write carries upper junk.
    write_config('0, '0, {44'hFFF_FFFF_FFFF, 7'h7F});
    @(posedge clk);
    cfg_write(CFG_UNMAPPED, RADIUS_FULL);
    cfg_we <= 1'b0;
    send_point(make_point(24'd100, 24'd100, 1'b0));
    send_point(make_point(24'd100, 24'd100, 1'b0));
    send_point(make_point(24'd101, 24'd100, 1'b1));

    // Unreachable critical level and a zero marginal level.
    write_config(PDC_RADIUS_RST, 51'd65, '0);
    send_point(make_point(24'd0, 24'd0, 1'b0));
    send_point(make_point(24'd1000, 24'd1000, 1'b0));
    send_point(make_point(COORD_MAX, 24'd0, 1'b1));

    // Random sets under changing settings; the first one overfills the store
    // so that points past capacity are dropped.
    first_set = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if (first_set || $urandom_range(0, 2) == 0) begin
        write_config(pick_radius(), pick_level(), pick_level());
      end
      if (first_set) begin
        set_size = 66;
      end else if ($urandom_range(0, 9) == 0) begin
        set_size = $urandom_range(60, 68);
      end else begin
        set_size = $urandom_range(1, 12);
      end
      first_set = 1'b0;
      random_set(set_size);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
